FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PAL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PAL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pal_pkg.sv
package pal_pkg;

  typedef logic [31:0] word_t;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Broadcast to every cell at the transfer edge of an insert or delete
  typedef struct packed {
    logic       ins;
    logic       del;
    logic [6:0] position;
    word_t      value;
  } shift_cmd_t;

  // Held steady while a probe travels the cell row
  typedef struct packed {
    logic       get;
    logic [6:0] position;
    word_t      value;
  } probe_cmd_t;

  // Token handed from cell to cell during a find or get
  typedef struct packed {
    logic       hit;
    word_t      word;
    logic [5:0] index;
  } probe_t;

endpackage

FILE: hw/rtl/pal_req_if.sv
interface pal_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

FILE: hw/rtl/pal_rsp_if.sv
interface pal_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [5:0]         found_index;
  logic [6:0]         count;

  modport source (output valid, output status, output read_value, output found_index,
                  output count, input ready);
  modport sink   (input valid, input status, input read_value, input found_index,
                  input count, output ready);
endinterface

FILE: hw/rtl/pal_cell.sv
module pal_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic                clk_i,
  input  pal_pkg::shift_cmd_t shift_i,
  input  pal_pkg::probe_cmd_t pcmd_i,
  input  logic [CW-1:0]       count_i,
  input  pal_pkg::word_t      left_i,
  input  pal_pkg::word_t      right_i,
  input  pal_pkg::probe_t     probe_i,
  output pal_pkg::word_t      entry_o,
  output pal_pkg::probe_t     probe_o
);
  import pal_pkg::*;

  localparam int IW = (CW > 7) ? CW : 7;
  localparam logic [IW-1:0] KIDX = IW'(INDEX);
  localparam logic [IW-1:0] KP1  = IW'(INDEX + 1);

  word_t   entry_q, entry_d;
  probe_t  probe_q, probe_d;
  logic [IW-1:0] spos_w, ppos_w, cnt_w;
  logic    live, match;

  assign spos_w = IW'(shift_i.position);
  assign ppos_w = IW'(pcmd_i.position);
  assign cnt_w  = IW'(count_i);

  // Entry update: take the new value, the lower neighbor, or the upper neighbor, else hold
  always_comb begin
    entry_d = entry_q;
    if (shift_i.ins) begin
      if (KP1 == spos_w) begin
        entry_d = shift_i.value;
      end else if (KP1 > spos_w) begin
        entry_d = left_i;
      end
    end else if (shift_i.del) begin
      if (KP1 >= spos_w) begin
        entry_d = right_i;
      end
    end
  end

  // Probe: first live cell that matches claims the token
  assign live  = KIDX < cnt_w;
  assign match = live && (pcmd_i.get ? (KIDX == ppos_w) : (entry_q == pcmd_i.value));

  always_comb begin
    probe_d = probe_i;
    if (!probe_i.hit && match) begin
      probe_d.hit   = 1'b1;
      probe_d.index = 6'(INDEX);
      probe_d.word  = pcmd_i.get ? entry_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    probe_q <= probe_d;
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;

endmodule

FILE: hw/rtl/positional_array_list.sv
// Channel  Dir  Payload                                   Transfer
// req_i    in   op, position, value                       valid && ready
// rsp_o    out  status, read_value, found_index, count    valid && ready
//
// Insert and delete shift the cell row at the request transfer edge; the result
// goes into the result registers, then into the output register once it is free.
// Find and get send a probe down the cell row, one cell per cycle; the sweep always
// runs to the last cell, whose token gives the result.
// One request in work at a time; the next is taken while a result waits in rsp_o.
// Reset empties the list (count zero); the entry cells are not cleared.
module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pal_req_if.sink          req_i,
  pal_rsp_if.source        rsp_o
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] sweep_q, sweep_d;

  probe_cmd_t    pcmd_q;
  shift_cmd_t    shift_w;

  status_e       res_status_q, res_status_d;
  word_t         res_read_q, res_read_d;
  logic [5:0]    res_index_q, res_index_d;
  logic [6:0]    res_count_q, res_count_d;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q;
  word_t         out_read_q;
  logic [5:0]    out_index_q;
  logic [6:0]    out_count_q;

  logic          req_xfer, out_load;
  logic [EW-1:0] pos_x, cnt_x;
  logic          ins_bad, del_bad, full;

  word_t         entry_w [CAPACITY];
  probe_t        probe_w [CAPACITY];
  probe_t        last_w;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  // Position checks against the current count
  assign pos_x   = EW'(req_i.position);
  assign cnt_x   = EW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign ins_bad = (req_i.position == 7'd0) || (pos_x > cnt_x + EW'(1));
  assign del_bad = (req_i.position == 7'd0) || (pos_x > cnt_x);

  assign shift_w.ins      = req_xfer && (req_i.op == OP_INSERT) && !ins_bad && !full;
  assign shift_w.del      = req_xfer && (req_i.op == OP_DELETE) && !del_bad;
  assign shift_w.position = req_i.position;
  assign shift_w.value    = req_i.value;

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t  left_w, right_w;
    probe_t pin_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
      assign pin_w  = '0;
    end else begin : g_body
      assign left_w = entry_w[g-1];
      assign pin_w  = probe_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = entry_w[g];
    end else begin : g_inner
      assign right_w = entry_w[g+1];
    end

    pal_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_w),
      .pcmd_i  (pcmd_q),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .probe_i (pin_w),
      .entry_o (entry_w[g]),
      .probe_o (probe_w[g])
    );
  end

  assign last_w   = probe_w[CAPACITY-1];
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // Sequencer and result assembly
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sweep_d      = sweep_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    res_index_d  = res_index_q;
    res_count_d  = res_count_q;

    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          res_read_d  = '0;
          res_index_d = '0;
          case (req_i.op)
            OP_INSERT: begin
              if (ins_bad) begin
                res_status_d = ST_BADPOS;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                res_status_d = ST_OK;
                count_d      = count_q + CW'(1);
              end
              state_d = S_DONE;
            end
            OP_DELETE: begin
              if (del_bad) begin
                res_status_d = ST_BADPOS;
              end else begin
                res_status_d = ST_OK;
                count_d      = count_q - CW'(1);
              end
              state_d = S_DONE;
            end
            default: begin
              sweep_d = '0;
              state_d = S_SWEEP;
            end
          endcase
          res_count_d = 7'(count_d);
        end
      end
      S_SWEEP: begin
        sweep_d = sweep_q + CW'(1);
        if (sweep_q == CW'(CAPACITY - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (last_w.hit) begin
          res_status_d = ST_OK;
        end else if (pcmd_q.get) begin
          res_status_d = ST_BADPOS;
        end else begin
          res_status_d = ST_NOTFOUND;
        end
        res_read_d  = last_w.word;
        res_index_d = (last_w.hit && !pcmd_q.get) ? last_w.index : '0;
        res_count_d = 7'(count_q);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      pcmd_q.get      <= (req_i.op == OP_GET);
      pcmd_q.position <= req_i.position;
      pcmd_q.value    <= req_i.value;
    end
    res_status_q <= res_status_d;
    res_read_q   <= res_read_d;
    res_index_q  <= res_index_d;
    res_count_q  <= res_count_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_read_q   <= res_read_q;
      out_index_q  <= res_index_q;
      out_count_q  <= res_count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_value  = out_read_q;
  assign rsp_o.found_index = out_index_q;
  assign rsp_o.count       = out_count_q;

endmodule

FILE: hw/rtl/pal_checker.sv
`include "assert_macros.svh"

module pal_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [31:0] rsp_read_value_i,
  input logic [5:0]  rsp_found_index_i,
  input logic [6:0]  rsp_count_i
);
  import pal_pkg::*;

  // A held result keeps its valid, status, read value and count until it transfers
  `PAL_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_read_value_i) && $stable(rsp_count_i), "rsp payload changed while stalled")

  // One request in work at a time
  `PAL_ASSERT_NXT(a_one_in_work, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while another is in work")

  // A full report leaves the count at capacity
  `PAL_ASSERT_IMP(a_full_count, clk_i, rst_ni, rsp_valid_i && rsp_status_i == ST_FULL, rsp_count_i == 7'(CAPACITY), "full status with count below capacity")

  // Bad-position and not-found results return zero data and index
  `PAL_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == ST_BADPOS || rsp_status_i == ST_NOTFOUND), rsp_read_value_i == 32'd0 && rsp_found_index_i == 6'd0, "failed result carries data")

endmodule

bind positional_array_list pal_checker #(
  .CAPACITY (CAPACITY)
) u_pal_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_found_index_i (rsp_o.found_index),
  .rsp_count_i       (rsp_o.count)
);
